// ===== hdl/crc16_record_deframer_core_defines.svh =====
// Assertion macros for the record deframer
`ifndef CRC16_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define CRC16_RECORD_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CRCDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CRCDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/crcdf_pkg.sv =====
// Types, constants and CRC function shared by the record deframer
`timescale 1ns / 1ps

package crcdf_pkg;

    localparam int unsigned SIZE_W = 23;
    localparam int unsigned CRC_W  = 16;

    localparam logic [15:0]       MAGIC_WORD        = 16'hDEAD;
    localparam logic [SIZE_W-1:0] MAX_RECORD_BYTES  = 23'd4194304;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT_RESET  = 23'd4194305;
    localparam logic [15:0]       CRC_POLY          = 16'hA001;
    localparam logic [2:0]        WINDOW_BYTES      = 3'd6;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_DATA   = 2'd1,
        PH_CRC_LO = 2'd2,
        PH_CRC_HI = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_ACCEPTED = 2'd1,
        EV_MISMATCH = 2'd2,
        EV_REJECTED = 2'd3
    } event_t;

    typedef struct packed {
        logic              vld;
        event_t            ev;
        logic [7:0]        payload;
        logic [SIZE_W-1:0] size;
        logic              last;
    } res_t;

    // CRC-16/ARC, reflected, one byte
    function automatic logic [CRC_W-1:0] crc_arc_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcdf_ifs.sv =====
// Channel interfaces: byte stream, result stream, size limit write
`timescale 1ns / 1ps

interface crcdf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface crcdf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  payload_byte;
    logic [22:0] record_size;
    logic        last;

    modport source (output valid, output event_res, output payload_byte,
                    output record_size, output last, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input record_size, input last, output ready);
endinterface

interface crcdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [22:0] size_limit;

    modport source (output valid, output size_limit, input ready);
    modport sink   (input valid, input size_limit, output ready);
endinterface

// ===== hdl/crcdf_parser.sv =====
// Record parser: header window, phase control, CRC and per-byte result
`timescale 1ns / 1ps

module crcdf_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step_en,
    input  logic [7:0]                     data_byte,
    input  logic [crcdf_pkg::SIZE_W-1:0]   size_limit,
    output crcdf_pkg::res_t                res
);
    import crcdf_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic [47:0]        window_reg, window_next;
    logic [2:0]         fill_reg,   fill_next;
    logic [SIZE_W-1:0]  left_reg,   left_next;
    logic [SIZE_W-1:0]  len_reg,    len_next;
    logic [CRC_W-1:0]   crc_reg,    crc_next;
    logic [7:0]         crc_lo_reg, crc_lo_next;

    logic [47:0]        win_shift;
    logic [2:0]         fill_inc;
    logic [31:0]        raw_len;
    logic               hdr_hit;
    logic               hdr_bad;
    logic [SIZE_W-1:0]  left_dec;
    logic [CRC_W-1:0]   crc_got;

    always_comb
    begin
        win_shift = {data_byte, window_reg[47:8]};
        fill_inc  = (fill_reg == WINDOW_BYTES) ? fill_reg : fill_reg + 3'd1;
        hdr_hit   = (fill_inc == WINDOW_BYTES) && (win_shift[15:0] == MAGIC_WORD);
        raw_len   = win_shift[47:16];
        // negative lengths fail through the sign bit
        hdr_bad   = raw_len[31]
                  || (raw_len >= {9'd0, size_limit})
                  || (raw_len > {9'd0, MAX_RECORD_BYTES});
        left_dec  = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        crc_got   = {data_byte, crc_lo_reg};
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (hdr_hit && !hdr_bad)
                begin
                    phase_next = (raw_len[SIZE_W-1:0] == '0) ? PH_CRC_LO : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (left_dec == '0)
                begin
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO: phase_next = PH_CRC_HI;
            PH_CRC_HI: phase_next = PH_HUNT;
            default:   phase_next = PH_HUNT;
        endcase
    end

    // datapath and result
    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        left_next   = left_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        res.vld     = 1'b0;
        res.ev      = EV_PAYLOAD;
        res.payload = 8'h00;
        res.size    = len_reg;
        res.last    = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                window_next = win_shift;
                fill_next   = fill_inc;
                if (hdr_hit)
                begin
                    if (hdr_bad)
                    begin
                        res.vld  = 1'b1;
                        res.ev   = EV_REJECTED;
                        res.size = MAX_RECORD_BYTES;
                        res.last = 1'b1;
                    end
                    else
                    begin
                        len_next    = raw_len[SIZE_W-1:0];
                        left_next   = raw_len[SIZE_W-1:0];
                        crc_next    = '0;
                        crc_lo_next = 8'h00;
                    end
                end
            end
            PH_DATA:
            begin
                crc_next    = crc_arc_byte(crc_reg, data_byte);
                left_next   = left_dec;
                res.vld     = 1'b1;
                res.payload = data_byte;
            end
            PH_CRC_LO:
            begin
                crc_lo_next = data_byte;
            end
            PH_CRC_HI:
            begin
                window_next = '0;
                fill_next   = 3'd0;
                res.vld     = 1'b1;
                res.ev      = (crc_got == crc_reg) ? EV_ACCEPTED : EV_MISMATCH;
                res.last    = 1'b1;
            end
            default:
            begin
                window_next = window_reg;
            end
        endcase
        if (!step_en)
        begin
            res.vld = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            fill_reg   <= 3'd0;
            left_reg   <= '0;
            len_reg    <= '0;
            crc_reg    <= '0;
            crc_lo_reg <= 8'h00;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            left_reg   <= left_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

// ===== hdl/crc16_record_deframer_core.sv =====
// Top level of the record deframer: input beat register, parser, result register
//
//  channel  | dir | payload                                   | beat taken when
//  ---------+-----+-------------------------------------------+-----------------
//  stream   | in  | data_byte                                 | valid && ready
//  result   | out | event_res, payload_byte, record_size, last| valid && ready
//  cfg      | in  | size_limit                                | valid && ready
//
//  One byte per cycle sustained while the result channel is not stalled.
//  Each byte passes input register -> parser (window, bytewise CRC) -> result register.
//  A byte is parsed only when the result register is free or being drained.
//  rst_n clears control state asynchronously; size_limit resets to 4194305.
//  Stalls on result back up into stream.ready after one buffered byte.
`timescale 1ns / 1ps
`include "crc16_record_deframer_core_defines.svh"

module crc16_record_deframer_core (
    input  logic         clk,
    input  logic         rst_n,
    crcdf_byte_if.sink   stream,
    crcdf_res_if.source  result,
    crcdf_cfg_if.sink    cfg
);
    import crcdf_pkg::*;

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_byte_reg;
    logic              out_vld_reg, out_vld_next;
    event_t            out_ev_reg;
    logic [7:0]        out_payload_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic              out_last_reg;
    logic [SIZE_W-1:0] size_limit_reg;
    logic              step_en;
    logic              in_take;
    res_t              res;

    assign step_en      = in_vld_reg && (!out_vld_reg || result.ready);
    assign stream.ready = !in_vld_reg || step_en;
    assign in_take      = stream.valid && stream.ready;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step_en)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step_en)
        begin
            out_vld_next = res.vld;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    crcdf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .data_byte  (in_byte_reg),
        .size_limit (size_limit_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            size_limit_reg <= SIZE_LIMIT_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid)
            begin
                size_limit_reg <= cfg.size_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= stream.data_byte;
        end
        if (step_en && res.vld)
        begin
            out_ev_reg      <= res.ev;
            out_payload_reg <= res.payload;
            out_size_reg    <= res.size;
            out_last_reg    <= res.last;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.event_res    = out_ev_reg;
    assign result.payload_byte = out_payload_reg;
    assign result.record_size  = out_size_reg;
    assign result.last         = out_last_reg;

    `CRCDF_ASSERT_NOW(a_last_on_verdict, out_vld_reg,
        out_last_reg == (out_ev_reg != EV_PAYLOAD), "last must mark verdict beats only")
    `CRCDF_ASSERT_NOW(a_verdict_no_data, out_vld_reg && (out_ev_reg != EV_PAYLOAD),
        out_payload_reg == 8'h00, "verdict beat carries payload data")
    `CRCDF_ASSERT_NOW(a_reject_size, out_vld_reg && (out_ev_reg == EV_REJECTED),
        out_size_reg == MAX_RECORD_BYTES, "rejected header must report max size")
    `CRCDF_ASSERT_NEXT(a_result_loaded, step_en && res.vld,
        out_vld_reg, "parsed result lost before result register")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the CRC-16 record deframer core
`timescale 1ns / 1ps

module tb;
    import crcdf_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        event_t            ev;
        logic [7:0]        payload;
        logic [SIZE_W-1:0] size;
        logic              last;
    } frame_event_t;

    logic clk = 1'b0;
    logic rst_n;

    crcdf_byte_if stream_if ();
    crcdf_res_if  result_if ();
    crcdf_cfg_if  cfg_if ();

    crc16_record_deframer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Parser shadow state
    logic [47:0]       hdr_window;
    logic [2:0]        hdr_fill;
    phase_t            parse_phase;
    logic [SIZE_W-1:0] payload_left;
    logic [SIZE_W-1:0] payload_len;
    logic [15:0]       crc_acc;
    logic [7:0]        crc_lo_rx;
    logic [SIZE_W-1:0] size_limit_shadow;

    frame_event_t frame_events_due[$];

    bit idle_on = 1'b1;
    int fail_count = 0;
    int bytes_sent = 0;
    int limit_writes = 0;
    int n_payload = 0;
    int n_accepted = 0;
    int n_mismatch = 0;
    int n_rejected = 0;
    int ready_hold = 0;
    int stall_cycles = 0;

    // Reflected CRC-16 (0xA001), one bit of the byte at a time
    function automatic logic [15:0] crc_arc_update(input logic [15:0] c, input logic [7:0] b);
        int  i;
        logic fb;
        for (i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ 16'hA001;
            end
        end
        return c;
    endfunction

    // Append one expected result beat to the scoreboard
    task automatic add_due_event(input frame_event_t e);
        frame_events_due = {frame_events_due, e};
    endtask

    task automatic deframe_predict(input logic [7:0] b);
        frame_event_t ev;
        logic [31:0]  raw;
        case (parse_phase)
            PH_DATA:
            begin
                crc_acc = crc_arc_update(crc_acc, b);
                if (payload_left != 0)
                begin
                    payload_left = payload_left - 1'b1;
                end
                if (payload_left == 0)
                begin
                    parse_phase = PH_CRC_LO;
                end
                ev = '{ev: EV_PAYLOAD, payload: b, size: payload_len, last: 1'b0};
                add_due_event(ev);
            end
            PH_CRC_LO:
            begin
                crc_lo_rx   = b;
                parse_phase = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                ev = '{ev: ({b, crc_lo_rx} == crc_acc) ? EV_ACCEPTED : EV_MISMATCH,
                       payload: 8'h00, size: payload_len, last: 1'b1};
                add_due_event(ev);
                parse_phase = PH_HUNT;
                hdr_fill    = 3'd0;
                hdr_window  = 48'h0;
            end
            default:
            begin
                hdr_window = {b, hdr_window[47:8]};
                if (hdr_fill < WINDOW_BYTES)
                begin
                    hdr_fill = hdr_fill + 1'b1;
                end
                if (hdr_fill == WINDOW_BYTES && hdr_window[15:0] == MAGIC_WORD)
                begin
                    raw = hdr_window[47:16];
                    // negative lengths count as oversized
                    if (raw[31] || raw >= size_limit_shadow || raw > MAX_RECORD_BYTES)
                    begin
                        ev = '{ev: EV_REJECTED, payload: 8'h00, size: MAX_RECORD_BYTES,
                               last: 1'b1};
                        add_due_event(ev);
                    end
                    else
                    begin
                        payload_len  = raw[SIZE_W-1:0];
                        payload_left = raw[SIZE_W-1:0];
                        crc_acc      = 16'h0;
                        crc_lo_rx    = 8'h00;
                        parse_phase  = (raw == 0) ? PH_CRC_LO : PH_DATA;
                    end
                end
            end
        endcase
    endtask

    // One stream beat; valid stays high on return so back-to-back beats have no bubble
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= b;
        @(posedge clk);
        while (!stream_if.ready) @(posedge clk);
        deframe_predict(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] raw);
        push_byte(MAGIC_WORD[7:0]);
        push_byte(MAGIC_WORD[15:8]);
        push_byte(raw[7:0]);
        push_byte(raw[15:8]);
        push_byte(raw[23:16]);
        push_byte(raw[31:24]);
    endtask

    task automatic send_record(input int unsigned len, input bit bad_crc);
        logic [15:0] c;
        logic [7:0]  pb;
        int          i;
        c = 16'h0;
        send_header(32'(len));
        for (i = 0; i < len; i++)
        begin
            pb = 8'($urandom);
            c  = crc_arc_update(c, pb);
            push_byte(pb);
        end
        if (bad_crc)
        begin
            c = c ^ 16'($urandom_range(1, 16'hFFFF));
        end
        push_byte(c[7:0]);
        push_byte(c[15:8]);
    endtask

    // Stop the stream, wait out all outstanding events plus pipeline slack
    task automatic settle_idle();
        stream_if.valid <= 1'b0;
        while (frame_events_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_size_limit(input logic [SIZE_W-1:0] v);
        settle_idle();
        cfg_if.valid      <= 1'b1;
        cfg_if.size_limit <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        size_limit_shadow = v;
        limit_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        send_record(0, 1'b0);            // empty payload, CRC of nothing is zero
        send_record(1, 1'b1);            // single byte, corrupted CRC
        send_header(32'hFFFF_FFFF);      // negative length
        push_byte(8'h00);
        push_byte(8'hFF);
        settle_idle();
    endtask

    task automatic test_size_limit_edges();
        logic [SIZE_W-1:0] limits[5];
        logic [SIZE_W-1:0] lim;
        int                k;
        limits = '{23'd0, 23'd1, 23'd7, SIZE_LIMIT_RESET, 23'h7FFFFF};
        for (k = 0; k < 5; k++)
        begin
            lim = limits[k];
            write_size_limit(lim);
            if (lim == 0)
            begin
                send_header(32'd0);      // zero limit rejects even an empty record
            end
            else
            begin
                send_record((lim <= 25) ? lim - 1 : 3, 1'($urandom));
                send_header({9'd0, lim});
            end
            send_header({9'd0, MAX_RECORD_BYTES} + 32'd1);
            send_header(32'h8000_0000);
            send_header(32'h7FFF_FFFF);
            send_header(32'h0080_0000);
        end
    endtask

    task automatic test_random_traffic(input int count);
        int          target;
        int          pick;
        int          n;
        int          i;
        logic [31:0] raw;
        logic [7:0]  pb;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
                send_record(n, $urandom_range(0, 3) == 0);
            end
            else if (pick < 75)
            begin
                case ($urandom_range(0, 2))
                    0:       raw = {1'b1, 31'($urandom)};
                    1:       raw = {9'd0, size_limit_shadow} + $urandom_range(0, 100);
                    default: raw = $urandom | 32'h0100_0000;
                endcase
                send_header(raw);
            end
            else if (pick < 85)
            begin
                // truncated record: later bytes get absorbed as payload
                n = $urandom_range(2, 20);
                send_header(32'(n));
                for (i = 0; i < $urandom_range(0, n - 1); i++)
                begin
                    push_byte(8'($urandom));
                end
            end
            else if (pick < 97)
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                begin
                    pb = ($urandom_range(0, 3) == 0) ?
                         (($urandom_range(0, 1) != 0) ? MAGIC_WORD[7:0] : MAGIC_WORD[15:8]) :
                         8'($urandom);
                    push_byte(pb);
                end
            end
            else
            begin
                settle_idle();
            end
        end
    endtask

    // Result sink: random ready stalls and in-order compare
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (frame_events_due.size() == 0)
            begin
                $error("unexpected result beat: event_res=%0d payload_byte=%0h",
                       result_if.event_res, result_if.payload_byte);
                fail_count++;
            end
            else
            begin
                frame_event_t exp_ev;
                exp_ev = frame_events_due.pop_front();
                if (result_if.event_res !== exp_ev.ev)
                begin
                    $error("event_res: expected %0d, actual %0d", exp_ev.ev, result_if.event_res);
                    fail_count++;
                end
                if (result_if.payload_byte !== exp_ev.payload)
                begin
                    $error("payload_byte: expected %0h, actual %0h",
                           exp_ev.payload, result_if.payload_byte);
                    fail_count++;
                end
                if (result_if.record_size !== exp_ev.size)
                begin
                    $error("record_size: expected %0d, actual %0d",
                           exp_ev.size, result_if.record_size);
                    fail_count++;
                end
                if (result_if.last !== exp_ev.last)
                begin
                    $error("last: expected %0b, actual %0b", exp_ev.last, result_if.last);
                    fail_count++;
                end
                case (exp_ev.ev)
                    EV_PAYLOAD:  n_payload++;
                    EV_ACCEPTED: n_accepted++;
                    EV_MISMATCH: n_mismatch++;
                    default:     n_rejected++;
                endcase
            end
        end
        if (ready_hold != 0)
        begin
            ready_hold--;
            result_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            ready_hold = $urandom_range(0, 14);
            result_if.ready <= 1'b0;
        end
        else
        begin
            result_if.ready <= 1'b1;
        end
    end

    // Watchdog: no beat on any channel for too long
    always @(posedge clk)
    begin
        if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = 8'h00;
        cfg_if.valid        = 1'b0;
        cfg_if.size_limit   = '0;
        hdr_window          = 48'h0;
        hdr_fill            = 3'd0;
        parse_phase         = PH_HUNT;
        payload_left        = '0;
        payload_len         = '0;
        crc_acc             = 16'h0;
        crc_lo_rx           = 8'h00;
        size_limit_shadow   = SIZE_LIMIT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_size_limit_edges();

        write_size_limit(SIZE_LIMIT_RESET);
        test_random_traffic(200);
        write_size_limit(23'($urandom_range(1, 40)));
        test_random_traffic(170);
        idle_on = 1'b0;
        write_size_limit(23'd32);
        test_random_traffic(110);
        settle_idle();

        $display("Run covered %0d stream bytes over %0d size_limit settings",
                 bytes_sent, limit_writes);
        $display("Seen: %0d payload beats, %0d accepted, %0d CRC mismatches, %0d rejects",
                 n_payload, n_accepted, n_mismatch, n_rejected);
        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
